@@ sv/uart_command_line_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// uart_command_line_receiver_defines
// Assertion macros used by the receiver core (ucl_rx_core).
// ----------------------------------------------------------------------------
`ifndef UART_COMMAND_LINE_RECEIVER_DEFINES_SVH
`define UART_COMMAND_LINE_RECEIVER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define UCL_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error("receiver check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define UCL_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error("receiver check failed");

`endif

@@ sv/ucl_pkg.sv @@
// ----------------------------------------------------------------------------
// ucl_pkg
// Types, codes and sizes shared by the command line receiver.
// ----------------------------------------------------------------------------
package ucl_pkg;

    // command buffer geometry
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

    // request function codes
    localparam logic [1:0] FUNC_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_END_CHAR = 2'd0;
    localparam logic [1:0] REG_BUF_SIZE = 2'd1;
    localparam logic [1:0] REG_ENABLE   = 2'd2;

    // register reset values
    localparam logic [7:0] END_CHAR_RST = 8'd10;
    localparam logic [6:0] BUF_SIZE_RST = 7'd64;
    localparam logic       ENABLE_RST   = 1'b1;

    // receiver status codes as reported
    localparam logic [1:0] STAT_WAIT = 2'd0;
    localparam logic [1:0] STAT_OVF  = 2'd1;
    localparam logic [1:0] STAT_END  = 2'd2;
    localparam logic [1:0] STAT_POST = 2'd3;

    typedef struct packed {
        logic [7:0] end_char;
        logic [6:0] buffer_size;
        logic       enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [2:0] rx_error;
        logic [5:0] entry_index;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] length;
        logic [7:0] overflow_count;
        logic [2:0] last_error;
        logic [7:0] last_char;
        logic       report_ready;
    } t_result;

endpackage

@@ sv/ucl_if.sv @@
// ----------------------------------------------------------------------------
// ucl_if
// Request and result channels of the command line receiver.
// ----------------------------------------------------------------------------

// request channel: one received byte or one operation
interface ucl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [2:0] rx_error;
    logic [5:0] entry_index;

    modport source (output valid, func, rx_byte, rx_error, entry_index, input ready);
    modport sink   (input valid, func, rx_byte, rx_error, entry_index, output ready);
endinterface

// result channel: one report per request
interface ucl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] length;
    logic [7:0] overflow_count;
    logic [2:0] last_error;
    logic [7:0] last_char;
    logic       report_ready;
    logic [7:0] entry_data;

    modport source (output valid, status, length, overflow_count, last_error,
                    last_char, report_ready, entry_data, input ready);
    modport sink   (input valid, status, length, overflow_count, last_error,
                    last_char, report_ready, entry_data, output ready);
endinterface

@@ sv/uart_command_line_receiver.sv @@
// ----------------------------------------------------------------------------
// uart_command_line_receiver
// Collects received UART bytes into a command buffer up to an end character.
// ----------------------------------------------------------------------------
// The receiver takes one request per clock while the result side is not
// stalled: a received byte, a take-report operation, a buffer read or a
// no-op. Each request passes an input register, then the state update,
// buffer write and buffer read settle into the result register, and a
// new request can follow every cycle. The 64-entry command buffer has
// one write port and one registered read port; its contents are undefined
// until written and there is no clearing pass after reset. A stalled result
// holds the result register and at most one more request waits in the input
// register. Configuration goes through the APB port, by the user only
// while no request is in flight (not enforced by the block); registers at
// byte addresses 0 (end character), 4 (buffer size) and 8 (enable).
module uart_command_line_receiver
    import ucl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ucl_in_if.sink      i_in,
    ucl_out_if.source   o_out
);

    t_cfg  cfg;
    logic  item_valid;
    t_item item;
    logic  advance;

    ucl_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ucl_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    ucl_rx_core u_rx_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (item_valid),
        .i_item    (item),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule

@@ sv/ucl_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ucl_cfg_regs
// APB register file: end character, buffer size and enable.
// ----------------------------------------------------------------------------
module ucl_cfg_regs
    import ucl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes; unmapped addresses are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.end_char    <= END_CHAR_RST;
            r_cfg.buffer_size <= BUF_SIZE_RST;
            r_cfg.enable      <= ENABLE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_END_CHAR: r_cfg.end_char    <= pwdata[7:0];
                REG_BUF_SIZE: r_cfg.buffer_size <= pwdata[6:0];
                REG_ENABLE:   r_cfg.enable      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_END_CHAR: prdata = {24'd0, r_cfg.end_char};
            REG_BUF_SIZE: prdata = {25'd0, r_cfg.buffer_size};
            REG_ENABLE:   prdata = {31'd0, r_cfg.enable};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/ucl_in_reg.sv @@
// ----------------------------------------------------------------------------
// ucl_in_reg
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
module ucl_in_reg
    import ucl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    ucl_in_if.sink i_in,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    // free when empty or when the held request moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.func        <= i_in.func;
            r_item.rx_byte     <= i_in.rx_byte;
            r_item.rx_error    <= i_in.rx_error;
            r_item.entry_index <= i_in.entry_index;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/ucl_rx_core.sv @@
// ----------------------------------------------------------------------------
// ucl_rx_core
// Receiver state, command buffer and result register.
// ----------------------------------------------------------------------------
`include "uart_command_line_receiver_defines.svh"

module ucl_rx_core
    import ucl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_advance,
    ucl_out_if.source o_out
);

    typedef enum logic [1:0] {
        ST_WAIT = STAT_WAIT,
        ST_OVF  = STAT_OVF,
        ST_END  = STAT_END,
        ST_POST = STAT_POST
    } t_rx_state;

    // receiver state
    t_rx_state         r_state, n_state, upd_state;
    logic [FILL_W-1:0] r_fill,  n_fill,  upd_fill;
    logic [7:0]        r_drop,  n_drop,  upd_drop;
    logic [2:0]        r_err,   n_err,   upd_err;
    logic [7:0]        r_last,  n_last,  upd_last;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;
    logic [7:0] r_rd_data;

    logic [7:0] mem [BUF_DEPTH];

    logic              step;
    logic              mem_we;
    logic              is_end;
    logic              take_ok;
    logic [FILL_W-1:0] eff_size;
    logic [FILL_W-1:0] fill_inc;

    assign o_advance = !r_out_valid || o_out.ready;
    assign step      = i_valid && o_advance;
    assign is_end    = (i_item.rx_byte == i_cfg.end_char);
    assign fill_inc  = r_fill + 1'b1;

    // buffer size clamped to 1..BUF_DEPTH
    always_comb begin
        if (i_cfg.buffer_size == 7'd0) begin
            eff_size = FILL_W'(1);
        end else if (FILL_W'(i_cfg.buffer_size) > FILL_W'(BUF_DEPTH)) begin
            eff_size = FILL_W'(BUF_DEPTH);
        end else begin
            eff_size = FILL_W'(i_cfg.buffer_size);
        end
    end

    // byte update, snapshot, then rearm on a taken report
    always_comb begin
        upd_state = r_state;
        upd_fill  = r_fill;
        upd_drop  = r_drop;
        upd_err   = r_err;
        upd_last  = r_last;
        mem_we    = 1'b0;

        if (i_item.func == FUNC_BYTE) begin
            upd_last = i_item.rx_byte;
            upd_err  = i_item.rx_error;
            if (i_cfg.enable) begin
                case (r_state)
                    ST_WAIT: begin
                        if (r_fill < eff_size) begin
                            mem_we   = 1'b1;
                            upd_fill = fill_inc;
                            if (is_end) begin
                                upd_state = ST_END;
                            end else if (fill_inc >= eff_size) begin
                                upd_state = ST_OVF;
                            end
                        end else begin
                            // size lowered under the fill point
                            upd_drop  = r_drop + 8'd1;
                            upd_state = is_end ? ST_END : ST_OVF;
                        end
                    end
                    ST_OVF: begin
                        upd_drop = r_drop + 8'd1;
                        if (is_end) begin
                            upd_state = ST_END;
                        end
                    end
                    ST_END:  upd_state = ST_POST;
                    default: ;
                endcase
            end
        end

        take_ok = (i_item.func == FUNC_REPORT) &&
                  (!i_cfg.enable || r_state == ST_END || r_state == ST_POST);

        n_out.status         = upd_state;
        n_out.length         = 7'(upd_fill);
        n_out.overflow_count = upd_drop;
        n_out.last_error     = upd_err;
        n_out.last_char      = upd_last;
        n_out.report_ready   = take_ok;

        if (take_ok) begin
            n_state = ST_WAIT;
            n_fill  = '0;
            n_drop  = 8'd0;
            n_err   = 3'd0;
            n_last  = 8'd0;
        end else begin
            n_state = upd_state;
            n_fill  = upd_fill;
            n_drop  = upd_drop;
            n_err   = upd_err;
            n_last  = upd_last;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_fill      <= '0;
            r_drop      <= 8'd0;
            r_err       <= 3'd0;
            r_last      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_out_valid <= i_valid;
            end
            if (step) begin
                r_state <= n_state;
                r_fill  <= n_fill;
                r_drop  <= n_drop;
                r_err   <= n_err;
                r_last  <= n_last;
                r_out   <= n_out;
            end
        end
    end

    // command buffer: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (step && mem_we) begin
            mem[r_fill[ADDR_W-1:0]] <= i_item.rx_byte;
        end
        if (step) begin
            r_rd_data <= (i_item.func == FUNC_READ) ?
                         mem[i_item.entry_index[ADDR_W-1:0]] : 8'd0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.length         = r_out.length;
    assign o_out.overflow_count = r_out.overflow_count;
    assign o_out.last_error     = r_out.last_error;
    assign o_out.last_char      = r_out.last_char;
    assign o_out.report_ready   = r_out.report_ready;
    assign o_out.entry_data     = r_rd_data;

    // a taken report leaves the receiver rearmed
    `UCL_ASSERT_NXT(a_rearm, step && take_ok, r_state == ST_WAIT && r_fill == '0)
    // overflow never stores a byte
    `UCL_ASSERT_NXT(a_ovf_hold, step && r_state == ST_OVF && !take_ok, $stable(r_fill))
    // a waiting result is not dropped
    `UCL_ASSERT_NXT(a_out_kept, r_out_valid && !o_out.ready, r_out_valid)
    // fill point stays inside the buffer
    `UCL_ASSERT_IMP(a_fill_range, r_out_valid, r_fill <= FILL_W'(BUF_DEPTH))

endmodule

@@ dv/tb_uart_command_line_receiver.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_command_line_receiver
// Self-checking bench for the UART command line receiver.
// ----------------------------------------------------------------------------
// Requests (bytes, take-report, buffer reads) go in through a valid/ready
// channel. A scoreboard keeps its own copy of the receiver state and
// predicts one report per request. Reports are compared field by field in
// order. Registers are changed over APB only while the receiver is idle, and
// each write is read back. A directed pass covers end, overflow, post-end,
// pause and size clamping. Random phases follow, mostly well-formed commands
// with some noise, under random stalls on both channels outside quiet phases.
module tb_uart_command_line_receiver;
    import ucl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES = 300;

    // one expected or observed report
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] length;
        logic [7:0] overflow_count;
        logic [2:0] last_error;
        logic [7:0] last_char;
        logic       report_ready;
        logic [7:0] entry_data;
    } t_rx_report;

    // receiver predictor and report checker
    class rx_scoreboard;
        logic [7:0]  cfg_end;
        logic [6:0]  cfg_size;
        logic        cfg_en;
        logic [1:0]  st;
        logic [6:0]  fill;
        logic [7:0]  cmd_mem [BUF_DEPTH];
        bit          written [BUF_DEPTH];
        int          n_written;
        logic [7:0]  dropped;
        logic [2:0]  lerr;
        logic [7:0]  lbyte;
        t_rx_report  expected [$];
        int          errors;
        int          n_checked;
        int          n_taken;

        function new();
            cfg_end = END_CHAR_RST;
            cfg_size = BUF_SIZE_RST;
            cfg_en = ENABLE_RST;
            foreach (written[k]) written[k] = 0;
            n_written = 0;
            errors = 0;
            n_checked = 0;
            n_taken = 0;
            clear_report();
        endfunction

        function void clear_report();
            st = STAT_WAIT;
            fill = '0;
            dropped = '0;
            lerr = '0;
            lbyte = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_END_CHAR: cfg_end = val[7:0];
                REG_BUF_SIZE: cfg_size = val[6:0];
                REG_ENABLE:   cfg_en = val[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_END_CHAR: return {24'd0, cfg_end};
                REG_BUF_SIZE: return {25'd0, cfg_size};
                REG_ENABLE:   return {31'd0, cfg_en};
                default:      return '0;
            endcase
        endfunction

        // per-byte state update
        function void rx_byte_update(logic [7:0] b, logic [2:0] e);
            logic [6:0] lim;
            lim = (cfg_size == 0) ? 7'd1 : (cfg_size > BUF_DEPTH) ? 7'(BUF_DEPTH) : cfg_size;
            lbyte = b;
            lerr = e;
            if (!cfg_en) return;
            case (st)
                STAT_WAIT: begin
                    if (fill < lim) begin
                        cmd_mem[fill[5:0]] = b;
                        if (!written[fill[5:0]]) n_written++;
                        written[fill[5:0]] = 1;
                        fill = fill + 1;
                        if (b == cfg_end) st = STAT_END;
                        else if (fill >= lim) st = STAT_OVF;
                    end else begin
                        dropped = dropped + 1;
                        st = (b == cfg_end) ? STAT_END : STAT_OVF;
                    end
                end
                STAT_OVF: begin
                    dropped = dropped + 1;
                    if (b == cfg_end) st = STAT_END;
                end
                STAT_END: st = STAT_POST;
                default: ;
            endcase
        endfunction

        // accepted request: predict its report
        function void note_request(t_item it);
            t_rx_report r;
            r = '0;
            if (it.func == FUNC_BYTE) rx_byte_update(it.rx_byte, it.rx_error);
            else if (it.func == FUNC_READ) r.entry_data = cmd_mem[it.entry_index];
            r.status = st;
            r.length = fill;
            r.overflow_count = dropped;
            r.last_error = lerr;
            r.last_char = lbyte;
            if (it.func == FUNC_REPORT && (!cfg_en || st == STAT_END || st == STAT_POST)) begin
                r.report_ready = 1'b1;
                n_taken++;
                clear_report();
            end
            expected.push_back(r);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void field_cmp(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // observed report against the oldest prediction
        function void check_report(t_rx_report got);
            t_rx_report want;
            if (expected.size() == 0) begin
                $display("%0t: report with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected.pop_front();
            n_checked++;
            field_cmp("status", want.status, got.status);
            field_cmp("length", want.length, got.length);
            field_cmp("overflow_count", want.overflow_count, got.overflow_count);
            field_cmp("last_error", want.last_error, got.last_error);
            field_cmp("last_char", want.last_char, got.last_char);
            field_cmp("report_ready", want.report_ready, got.report_ready);
            field_cmp("entry_data", want.entry_data, got.entry_data);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ucl_in_if  in_ch ();
    ucl_out_if out_ch ();

    rx_scoreboard sb;
    bit quiet;
    bit hold_req;
    int n_items;
    int n_phases;
    int cycles;

    uart_command_line_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side ready: random stalls, quiet stretches, one long hold-off
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 31);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rx_report got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = out_ch.status;
            got.length = out_ch.length;
            got.overflow_count = out_ch.overflow_count;
            got.last_error = out_ch.last_error;
            got.last_char = out_ch.last_char;
            got.report_ready = out_ch.report_ready;
            got.entry_data = out_ch.entry_data;
            sb.check_report(got);
        end
    end

    function automatic t_item mk_req(logic [1:0] f, logic [7:0] b, logic [2:0] e,
                                     logic [5:0] x);
        t_item it;
        it.func = f;
        it.rx_byte = b;
        it.rx_error = e;
        it.entry_index = x;
        return it;
    endfunction

    // random entry that holds a stored byte
    function automatic logic [5:0] pick_stored();
        int k;
        k = $urandom_range(BUF_DEPTH - 1);
        while (!sb.written[k]) k = (k + 1) % BUF_DEPTH;
        return 6'(k);
    endfunction

    // one request, with idle cycles ahead of it at random
    task automatic send_req(input t_item it);
        while (!quiet && $urandom_range(99) < 31) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= it.func;
        in_ch.rx_byte <= it.rx_byte;
        in_ch.rx_error <= it.rx_error;
        in_ch.entry_index <= it.entry_index;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(it);
        n_items++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [2:0] e);
        send_req(mk_req(FUNC_BYTE, b, e, 6'($urandom_range(63))));
    endtask

    task automatic send_op(input logic [1:0] f, input logic [5:0] x);
        send_req(mk_req(f, 8'($urandom_range(255)), 3'($urandom_range(7)), x));
    endtask

    // stop sending and wait out every report plus the pipeline latency
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write, then read back
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, val);
        want = sb.reg_value(idx);
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, idx, want, prdata);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // well-formed command: body, end character, maybe trailing bytes, reads, take
    task automatic run_command();
        int len;
        int npost;
        int nreads;
        logic [7:0] b;
        len = ($urandom_range(5) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 10);
        npost = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        nreads = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (b == sb.cfg_end) b = b ^ 8'h01;
            send_byte(b, 3'($urandom_range(7)));
        end
        send_byte(sb.cfg_end, 3'($urandom_range(7)));
        repeat (npost) send_byte(8'($urandom_range(255)), 3'($urandom_range(7)));
        repeat (nreads) if (sb.n_written != 0) send_op(FUNC_READ, pick_stored());
        send_op(FUNC_REPORT, 6'($urandom_range(63)));
    endtask

    // unstructured requests, any function
    task automatic run_noise();
        logic [1:0] f;
        repeat ($urandom_range(1, 8)) begin
            f = 2'($urandom_range(3));
            if (f == FUNC_READ && sb.n_written == 0) f = FUNC_BYTE;
            if (f == FUNC_READ) send_op(f, pick_stored());
            else send_req(mk_req(f, 8'($urandom_range(255)), 3'($urandom_range(7)),
                                 6'($urandom_range(63))));
        end
    endtask

    // main sequence
    initial begin
        logic [6:0] sz;
        sb = new();
        quiet = 0;
        hold_req = 0;
        n_items = 0;
        n_phases = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.func <= FUNC_BYTE;
        in_ch.rx_byte <= '0;
        in_ch.rx_error <= '0;
        in_ch.entry_index <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // take before anything arrived, unused function, full command, post-end
        send_op(FUNC_REPORT, 6'd0);
        send_op(FUNC_NONE, 6'd63);
        send_byte(8'h00, 3'd7);
        send_byte(8'hFF, 3'd0);
        send_byte(8'h0A, 3'd1);
        send_byte(8'h55, 3'd2);
        send_byte(8'hAA, 3'd4);
        send_op(FUNC_READ, 6'd0);
        send_op(FUNC_READ, 6'd2);
        send_op(FUNC_REPORT, 6'd0);

        // one-entry buffer: overflow, early take refused, end char zero
        settle();
        cfg_write(REG_END_CHAR, 32'd0);
        cfg_write(REG_BUF_SIZE, 32'd1);
        send_byte(8'h41, 3'd3);
        send_byte(8'h42, 3'd5);
        send_op(FUNC_REPORT, 6'd0);
        send_byte(8'h00, 3'd6);
        send_op(FUNC_REPORT, 6'd0);

        // buffer shrunk below the fill position, end char arrives while full
        settle();
        cfg_write(REG_END_CHAR, 32'd255);
        cfg_write(REG_BUF_SIZE, 32'd64);
        send_byte(8'h01, 3'd0);
        send_byte(8'h02, 3'd0);
        send_byte(8'h03, 3'd0);
        settle();
        cfg_write(REG_BUF_SIZE, 32'd2);
        send_byte(8'hFF, 3'd1);
        send_op(FUNC_REPORT, 6'd0);

        // paused: only last byte fields move, take always succeeds
        settle();
        cfg_write(REG_ENABLE, 32'd0);
        send_byte(8'h33, 3'd5);
        send_op(FUNC_REPORT, 6'd0);
        send_op(FUNC_READ, 6'd1);

        // size zero acts as one
        settle();
        cfg_write(REG_ENABLE, 32'd1);
        cfg_write(REG_BUF_SIZE, 32'd0);
        send_byte(8'h77, 3'd2);
        send_op(FUNC_REPORT, 6'd0);

        // random phases: fresh settings each time, state carried over
        while (n_items < RANDOM_ITEMS + 30) begin
            n_phases++;
            settle();
            quiet = (n_phases >= 3 && n_phases <= 7);
            case ($urandom_range(9))
                0: sz = 7'd1;
                1: sz = 7'd64;
                2: sz = 7'd0;
                3: sz = 7'd127;
                4, 5: sz = 7'($urandom_range(2, 8));
                default: sz = 7'($urandom_range(1, 64));
            endcase
            cfg_write(REG_END_CHAR, ($urandom_range(3) == 0) ? 32'd10 : $urandom_range(255));
            cfg_write(REG_BUF_SIZE, {25'd0, sz});
            cfg_write(REG_ENABLE, ($urandom_range(9) == 0) ? 32'd0 : 32'd1);
            // long receiver hold-off while requests keep coming
            if (n_phases == 10) hold_req = 1;
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(99) < 75) run_command();
                else run_noise();
            end
        end

        settle();
        quiet = 0;
        $display("covered %0d requests in %0d random phases, %0d reports checked",
                 n_items, n_phases, sb.n_checked);
        $display("%0d commands taken, %0d buffer entries stored at least once",
                 sb.n_taken, sb.n_written);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
